FILE: hdl/assert_macros.svh
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BDQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bdq_pkg.sv
// Package with the word types, operation codes and status codes of the deque.
`timescale 1ns / 1ps

package bdq_pkg;

   // Operation codes of a request word.
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_POP_BACK   = 3'd1;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_FIND       = 3'd4;

   // Status codes of a response word.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   // Request word.
   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] length;
   } rsp_type;

   // Outcome of a search, handed from the scan unit to the control logic.
   typedef struct packed {
      logic       done;
      logic       found;
      logic [3:0] position;
   } scan_result_type;

endpackage

FILE: hdl/bdq_mem.sv
// Entry store of the deque: one write port and one registered read port.
`timescale 1ns / 1ps

module bdq_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bdq_scan.sv
// Search sequencer: walks the live entries from the front through one comparator.
`timescale 1ns / 1ps

module bdq_scan
   import bdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4,
   parameter int CW         = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch,
   input  logic [AW-1:0]         front,
   input  logic [CW-1:0]         count,
   input  logic [DATA_WIDTH-1:0] key,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [DATA_WIDTH-1:0] rd_data,
   output scan_result_type       result
);

   localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

   logic          run_ff, run_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [AW:0]   slot_sum;
   logic          match;
   logic [AW+3:0] pos_ext;

   // Read address: offset from the front, wrapped once into the store.
   assign slot_sum = {1'b0, front} + {1'b0, issue_ff[AW-1:0]};
   assign rd_addr  = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : slot_sum[AW-1:0];
   assign rd_en    = run_ff && (issue_ff < count);

   // The comparator sees the entry read in the previous cycle.
   assign match   = cmp_valid_ff && (rd_data == key);
   assign pos_ext = {4'b0000, cmp_idx_ff};

   always_comb begin
      result.done     = run_ff && (match || (!rd_en && !cmp_valid_ff));
      result.found    = match;
      result.position = match ? pos_ext[3:0] : 4'd0;
   end

   // Sequencer: one read issued and one compare made in every cycle while a search runs and entries remain.
   always_comb begin
      run_in       = run_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      if (launch) begin
         run_in   = 1'b1;
         issue_in = '0;
      end else if (run_ff) begin
         if (result.done) begin
            run_in = 1'b0;
         end else if (rd_en) begin
            issue_in     = issue_ff + CW'(1);
            cmp_valid_in = 1'b1;
            cmp_idx_in   = issue_ff[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

endmodule

FILE: hdl/bounded_deque_with_search.sv
// Push and pop: response in the cycle after start; the next word is taken in that same cycle.
// Find: busy from start until the response; the single comparator
// reads the store one entry per cycle from the front.
// Find on an empty deque and unused operations answer in the cycle after start.
// Synchronous reset empties the deque (front slot and count to zero); no store clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // Sequencer states.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_FIND = 1'b1;

   logic                  state_ff, state_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] key_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [DATA_WIDTH+31:0] value_ext;
   logic [DATA_WIDTH-1:0] word;
   logic [AW:0]           back_sum;
   logic [AW-1:0]         back_slot;
   logic [AW-1:0]         front_dec;
   logic [AW-1:0]         front_inc;
   logic [CW+4:0]         len_ext;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  launch;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   scan_result_type       scan_res;

   logic                  quick_op;
   logic                  push_op;
   logic                  full_push;

   assign busy   = (state_ff == S_FIND);
   assign accept = start && !busy;

   // The stored word is the low DATA_WIDTH bits of the value, zero-extended when wider.
   assign value_ext = {{DATA_WIDTH{1'b0}}, req_data.value};
   assign word      = value_ext[DATA_WIDTH-1:0];

   // Slot behind the last entry, and the neighbours of the front slot.
   assign back_sum  = {1'b0, front_ff} + {1'b0, count_ff[AW-1:0]};
   assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : back_sum[AW-1:0];
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - AW'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + AW'(1);

   // Operation decode and response assembly.
   always_comb begin
      state_in             = state_ff;
      front_in             = front_ff;
      count_in             = count_ff;
      wr_en                = 1'b0;
      wr_addr              = back_slot;
      launch               = 1'b0;
      rsp_valid_in         = 1'b0;
      rsp_data_in.status   = STAT_OK;
      rsp_data_in.position = 4'd0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_data.operation)
            OP_PUSH_BACK: begin
               if (count_ff >= FULL_CNT) begin
                  rsp_data_in.status = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (count_ff >= FULL_CNT) begin
                  rsp_data_in.status = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = STAT_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            OP_FIND: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = STAT_NOT_FOUND;
               end else begin
                  rsp_valid_in = 1'b0;
                  launch       = 1'b1;
                  state_in     = S_FIND;
               end
            end
            default: begin
               rsp_data_in.status = STAT_OK;
            end
         endcase
      end else if (busy && scan_res.done) begin
         state_in             = S_IDLE;
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = scan_res.found ? STAT_OK : STAT_NOT_FOUND;
         rsp_data_in.position = scan_res.position;
      end
      len_ext            = {5'b00000, count_in};
      rsp_data_in.length = len_ext[4:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: search key and response word.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= word;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bdq_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdq_scan #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .launch  (launch),
      .front   (front_ff),
      .count   (count_ff),
      .key     (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .result  (scan_res)
   );

   // Request classes used by the checks below.
   assign quick_op  = !(req_data.operation == OP_FIND && count_ff != '0);
   assign push_op   = (req_data.operation == OP_PUSH_BACK) ||
                      (req_data.operation == OP_PUSH_FRONT);
   assign full_push = accept && push_op && (count_ff == FULL_CNT);

   // The count never exceeds the store depth.
   `BDQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= FULL_CNT, "entry count above depth")
   // Every operation other than a search on a non-empty deque answers in the next cycle.
   `BDQ_ASSERT_NEXT(a_quick_rsp, accept && quick_op, rsp_valid_ff, "missing one-cycle response")
   // The store is never written while a search walks it.
   `BDQ_ASSERT_SAME(a_no_write_in_find, state_ff == S_FIND, !wr_en, "store written during search")
   // A rejected push leaves the count as it was.
   `BDQ_ASSERT_NEXT(a_full_hold, full_push, count_ff == FULL_CNT, "rejected push moved count")

endmodule
